### rtl/core/trpr_pkg.sv
// ----------------------------------------------------------------------------
// trpr_pkg
// shared types and constants of the temperature rise point recorder
// ----------------------------------------------------------------------------
`default_nettype none

package trpr_pkg;

  // widths of values and times
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned TM_W   = 31;   // non-negative time, saturating
  localparam int unsigned MTM_W  = 32;   // middle time, may hold -1
  localparam int unsigned RISE_W = 15;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 1;

  localparam logic [TM_W-1:0]  TIME_MAX    = {TM_W{1'b1}};
  localparam logic [MTM_W-1:0] MID_TM_FIX  = {MTM_W{1'b1}};   // fixed start marker

  // register indexes
  localparam logic [IDX_W-1:0] CFG_MIN_RISE  = 1'b0;
  localparam logic [IDX_W-1:0] CFG_TICK_STEP = 1'b1;

  localparam logic [RISE_W-1:0] MIN_RISE_RST  = 15'd128;
  localparam logic [TICK_W-1:0] TICK_STEP_RST = 16'd10;

  // kind codes
  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_SAMPLE  = 1'b1;

  typedef struct packed {
    logic [RISE_W-1:0] min_rise;
    logic [TICK_W-1:0] tick_step;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] start_val;
    logic [VAL_W-1:0] middle_val;
    logic [MTM_W-1:0] middle_tm;
    logic [VAL_W-1:0] latest_val;
    logic [TM_W-1:0]  latest_tm;
    logic [VAL_W-1:0] doubled_val;
    logic [TM_W-1:0]  doubled_tm;
    logic [TM_W-1:0]  step_begin_tm;
    logic [TM_W-1:0]  elapsed;
  } rec_t;

endpackage

`default_nettype wire

### rtl/core/trpr_cfg_regs.sv
// ----------------------------------------------------------------------------
// trpr_cfg_regs
// configuration registers, written through a plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module trpr_cfg_regs (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire [trpr_pkg::IDX_W-1:0]   cfg_idx,
  input  wire [trpr_pkg::CFG_W-1:0]   cfg_wdata,
  output trpr_pkg::cfg_t              cfg
);

  trpr_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        trpr_pkg::CFG_MIN_RISE:  cfg_nxt.min_rise  = cfg_wdata[trpr_pkg::RISE_W-1:0];
        trpr_pkg::CFG_TICK_STEP: cfg_nxt.tick_step = cfg_wdata[trpr_pkg::TICK_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_rise  <= trpr_pkg::MIN_RISE_RST;
      cfg_r.tick_step <= trpr_pkg::TICK_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/core/trpr_core.sv
// ----------------------------------------------------------------------------
// trpr_core
// record state and its single-pass update for one beat
// ----------------------------------------------------------------------------
`default_nettype none

module trpr_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          upd_en,
  input  wire                          kind,
  input  wire [trpr_pkg::VAL_W-1:0]    value,
  input  trpr_pkg::cfg_t               cfg,
  output trpr_pkg::rec_t               rec
);

  localparam int unsigned TW = trpr_pkg::TM_W;
  localparam int unsigned VW = trpr_pkg::VAL_W;
  localparam int unsigned MW = trpr_pkg::MTM_W;

  trpr_pkg::rec_t rec_r, rec_nxt;

  logic [VW+1:0] v_ext, thr;
  logic          risen;
  logic          started;
  logic [TW:0]   tick_sum;
  logic [TW-1:0] e1;
  logic [TW:0]   avg_sum;
  logic [TW-1:0] avg;
  logic [TW-1:0] e_back;
  logic [TW-1:0] el, lt, dt;
  logic [MW-1:0] mt;
  logic [VW-1:0] mv, dv;

  // latest time against twice the reference period (reference time positive)
  function automatic logic period_doubled(input logic [TW-1:0] l_tm,
                                          input logic [VW-1:0] d_val,
                                          input logic [TW-1:0] d_tm,
                                          input logic [MW-1:0] m_tm);
    logic [TW:0] ref2;
    begin
      ref2 = (d_val == '0) ? {m_tm[TW-1:0], 1'b0} : {d_tm, 1'b0};
      period_doubled = ({1'b0, l_tm} >= ref2);
    end
  endfunction

  always_comb begin
    v_ext    = {{2{value[VW-1]}}, value};
    thr      = {{2{rec_r.latest_val[VW-1]}}, rec_r.latest_val} +
               {{(VW+2-trpr_pkg::RISE_W){1'b0}}, cfg.min_rise};
    risen    = ($signed(v_ext) >= $signed(thr));
    started  = (rec_r.start_val != '0);

    // clock advance with saturation
    tick_sum = {1'b0, rec_r.elapsed} + {{(TW+1-trpr_pkg::TICK_W){1'b0}}, cfg.tick_step};
    e1       = tick_sum[TW] ? trpr_pkg::TIME_MAX : tick_sum[TW-1:0];
    avg_sum  = {1'b0, e1} + {1'b0, rec_r.step_begin_tm};
    avg      = avg_sum[TW:1];
    e_back   = (e1 >= rec_r.latest_tm) ? (e1 - rec_r.latest_tm) : '0;

    rec_nxt  = rec_r;
    el = e1;
    lt = rec_r.latest_tm;
    mt = rec_r.middle_tm;
    mv = rec_r.middle_val;
    dv = rec_r.doubled_val;
    dt = rec_r.doubled_tm;

    if (kind == trpr_pkg::KIND_RESTART) begin
      rec_nxt            = '0;
      rec_nxt.latest_val = value;
    end else if (!started && risen) begin
      rec_nxt.start_val  = value;
      rec_nxt.latest_val = value;
      rec_nxt.elapsed    = '0;
    end else if (rec_r.latest_val == value) begin
      // repeated value: average the dwell time
      rec_nxt.elapsed   = e1;
      rec_nxt.latest_tm = avg;
      if (!mt[MW-1] && (mt != '0) && period_doubled(avg, dv, dt, mt)) begin
        if (dv != '0) begin
          rec_nxt.middle_val = dv;
          rec_nxt.middle_tm  = {1'b0, dt};
        end
        rec_nxt.doubled_val = rec_r.latest_val;
        rec_nxt.doubled_tm  = avg;
      end
    end else begin
      // first change of value moves the time origin
      if (mt == '0) begin
        el = e_back;
        mt = trpr_pkg::MID_TM_FIX;
        lt = '0;
      end
      if (risen) begin
        if (mt[MW-1] || (mt == '0)) begin
          mv = value;
          if (lt == '0) begin
            lt = el;
          end
          mt = {1'b0, lt};
        end else if (period_doubled(lt, dv, dt, mt)) begin
          if (dv != '0) begin
            mv = dv;
            mt = {1'b0, dt};
          end
          dv = rec_r.latest_val;
          dt = lt;
        end
        if (rec_r.latest_val == mv) begin
          mt = {1'b0, lt};
        end
        if (rec_r.latest_val == dv) begin
          dt = lt;
        end
        rec_nxt.latest_val    = value;
        rec_nxt.latest_tm     = el;
        rec_nxt.step_begin_tm = el;
      end else begin
        rec_nxt.latest_tm = lt;
      end
      rec_nxt.elapsed     = el;
      rec_nxt.middle_tm   = mt;
      rec_nxt.middle_val  = mv;
      rec_nxt.doubled_val = dv;
      rec_nxt.doubled_tm  = dt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else if (upd_en) begin
      rec_r <= rec_nxt;
    end
  end

  assign rec = rec_r;

endmodule

`default_nettype wire

### rtl/core/temperature_rise_point_recorder_unit.sv
// ----------------------------------------------------------------------------
// temperature_rise_point_recorder_unit
// records start, middle, doubled-period and latest points of a heating rise
// ----------------------------------------------------------------------------
// path: the accepting edge loads the input register, and the record update then
//   loads the record registers, once the result slot is free or leaving
// throughput: one beat per cycle, set by the record update loop;
//   a stalled result beat holds the input register and so the input side
// reset: synchronous, active low; clears all records, both valid flags and
//   loads min_rise = 128, tick_step = 10
`default_nettype none

module temperature_rise_point_recorder_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  // input channel
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            in_kind,
  input  wire signed [15:0]              in_value,
  // result channel
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [15:0]             out_start_value,
  output logic signed [15:0]             out_mid_value,
  output logic signed [31:0]             out_mid_time,
  output logic signed [15:0]             out_latest_value,
  output logic [30:0]                    out_latest_time,
  output logic                           out_fit_ready,
  // configuration write port
  input  wire                            cfg_we,
  input  wire [trpr_pkg::IDX_W-1:0]      cfg_idx,
  input  wire [trpr_pkg::CFG_W-1:0]      cfg_wdata
);

  trpr_pkg::cfg_t cfg;
  trpr_pkg::rec_t rec;

  // input register
  logic                        in_vld_r, in_vld_nxt;
  logic                        in_kind_r;
  logic [trpr_pkg::VAL_W-1:0]  in_value_r;
  // result valid; the record registers double as the result register
  logic                        out_vld_r, out_vld_nxt;
  logic                        advance;
  logic                        in_take;

  // the update fires when an item waits and the result slot is free or leaving
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign in_take  = in_valid && in_ready;

  assign in_vld_nxt  = in_take || (in_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && !out_ready);

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_kind_r  <= in_kind;
      in_value_r <= in_value;
    end
  end

  trpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // record state updates only when the beat moves on, so a stalled
  // result keeps its fields
  trpr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (advance),
    .kind   (in_kind_r),
    .value  (in_value_r),
    .cfg    (cfg),
    .rec    (rec)
  );

  assign out_valid        = out_vld_r;
  assign out_start_value  = rec.start_val;
  assign out_mid_value    = rec.middle_val;
  assign out_mid_time     = rec.middle_tm;
  assign out_latest_value = rec.latest_val;
  assign out_latest_time  = rec.latest_tm;
  // a fit needs a middle record that differs from the latest step
  assign out_fit_ready    = (rec.middle_val != '0) && (rec.latest_val != rec.middle_val);

endmodule

`default_nettype wire

### rtl/core/trpr_checker.sv
// ----------------------------------------------------------------------------
// trpr_checker
// port-level checks of the recorder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module trpr_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_ready,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire signed [15:0] out_start_value,
  input  wire signed [15:0] out_mid_value,
  input  wire signed [31:0] out_mid_time,
  input  wire signed [15:0] out_latest_value,
  input  wire [30:0]        out_latest_time,
  input  wire               out_fit_ready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mid_time) &&
    $stable(out_latest_time) && $stable(out_latest_value))
    else $error("result beat changed while stalled");

  // with the result slot empty the input side is never blocked
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result slot");

  // fit flag follows the records it reports
  a_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fit_ready ==
      ((out_mid_value != 16'sd0) && (out_latest_value != out_mid_value)))
    else $error("fit flag inconsistent with records");

  // a middle record only exists once timing has started
  a_mid_started: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mid_value != 16'sd0) |-> (out_start_value != 16'sd0))
    else $error("middle record without start");

  // reset empties the result slot
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind temperature_rise_point_recorder_unit trpr_checker u_trpr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_start_value  (out_start_value),
  .out_mid_value    (out_mid_value),
  .out_mid_time     (out_mid_time),
  .out_latest_value (out_latest_value),
  .out_latest_time  (out_latest_time),
  .out_fit_ready    (out_fit_ready)
);

`default_nettype wire
